### hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // operation codes carried in in_tuser
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // result status codes carried in out_tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // fixed field widths of the stream beats
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned PRIO_FIELD  = 16;
  localparam int unsigned COUNT_FIELD = 5;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;   // insert the new entry in sorted place
    logic deq;   // shift every entry one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int unsigned PRI_W = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  wire  [31:0]                new_value,
  input  wire  [PRI_W-1:0]           new_pri,
  input  wire                        left_greater,
  input  wire                        left_occ,
  input  wire  [31:0]                left_value,
  input  wire  [PRI_W-1:0]           left_pri,
  input  wire                        right_occ,
  input  wire  [31:0]                right_value,
  input  wire  [PRI_W-1:0]           right_pri,
  output logic                       greater,
  output logic                       occ_r,
  output logic [31:0]                value_r,
  output logic [PRI_W-1:0]           pri_r,
  output logic                       occ_nxt,
  output logic [31:0]                value_nxt,
  output logic [PRI_W-1:0]           pri_nxt
);
  import spq_pkg::*;

  // new entry belongs at or before this cell; equal priority stays in front
  assign greater = !occ_r || (pri_r > new_pri);

  // next contents: hold, take new entry, take left neighbor or right neighbor
  always_comb begin
    occ_nxt   = occ_r;
    value_nxt = value_r;
    pri_nxt   = pri_r;
    if (ctrl.enq && greater) begin
      if (left_greater) begin
        occ_nxt   = left_occ;
        value_nxt = left_value;
        pri_nxt   = left_pri;
      end else begin
        occ_nxt   = 1'b1;
        value_nxt = new_value;
        pri_nxt   = new_pri;
      end
    end else if (ctrl.deq) begin
      occ_nxt   = right_occ;
      value_nxt = right_value;
      pri_nxt   = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pri_r   <= pri_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue of DEPTH entries held in a row of compare-and-shift
// cells, head in cell 0, smallest priority number first, equal priorities in
// arrival order. Each input beat carries one operation in in_tuser (enqueue,
// dequeue, peek; the unused code acts as a peek) and yields exactly one result
// beat with the status, the head entry after the operation (zero when empty)
// and the entry count. Every cell decides its next contents from its own
// compare and its neighbors in the same cycle, so one operation completes per
// clock: a new beat is accepted every cycle while the result register is
// empty or being drained. Enqueue into a full queue is dropped with status
// full; dequeue or peek on an empty queue reports empty.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // [31:0] item_value, [47:32] item_priority
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // [31:0] head_value, [47:32] head_priority,
                                  // [52:48] entry_count, [55:53] zero
  output logic [2:0]  out_tuser   // [1:0] status, [2] head_valid
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // cell array taps
  logic [31:0]              c_value_r   [DEPTH];
  logic [PRIORITY_BITS-1:0] c_pri_r     [DEPTH];
  logic [DEPTH-1:0]         c_occ_r;
  logic [DEPTH-1:0]         c_greater;
  logic [31:0]              c_value_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0] c_pri_nxt   [DEPTH];
  logic [DEPTH-1:0]         c_occ_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r;
  logic [55:0]              out_data_r;
  logic [2:0]               out_user_r;

  logic                     accept;
  logic                     full, empty;
  logic [1:0]               status;
  cell_ctrl_t               ctrl;
  logic [31:0]              new_value;
  logic [PRIORITY_BITS-1:0] new_pri;
  logic [31:0]              pri_ext;
  logic [31:0]              head_pri_ext;
  logic [31:0]              cnt_ext;

  // handshake: the result register parts the two sides
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // input unpacking, priority trimmed or widened to storage width
  assign new_value = in_tdata[31:0];
  always_comb begin
    pri_ext        = '0;
    pri_ext[15:0]  = in_tdata[47:32];
  end
  assign new_pri = pri_ext[PRIORITY_BITS-1:0];

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // decode operation into cell command and status
  always_comb begin
    ctrl      = '0;
    status    = ST_OK;
    count_nxt = count_r;
    case (in_tuser)
      MODE_ENQ: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.enq  = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.deq  = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
    endcase
  end

  // the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_greater, l_occ, r_occ;
    logic [31:0]              l_value, r_value;
    logic [PRIORITY_BITS-1:0] l_pri, r_pri;

    if (i == 0) begin : g_head
      assign l_greater = 1'b0;
      assign l_occ     = 1'b0;
      assign l_value   = '0;
      assign l_pri     = '0;
    end else begin : g_mid
      assign l_greater = c_greater[i-1];
      assign l_occ     = c_occ_r[i-1];
      assign l_value   = c_value_r[i-1];
      assign l_pri     = c_pri_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_occ   = 1'b0;
      assign r_value = '0;
      assign r_pri   = '0;
    end else begin : g_body
      assign r_occ   = c_occ_r[i+1];
      assign r_value = c_value_r[i+1];
      assign r_pri   = c_pri_r[i+1];
    end

    spq_cell #(
      .PRI_W (PRIORITY_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .new_value    (new_value),
      .new_pri      (new_pri),
      .left_greater (l_greater),
      .left_occ     (l_occ),
      .left_value   (l_value),
      .left_pri     (l_pri),
      .right_occ    (r_occ),
      .right_value  (r_value),
      .right_pri    (r_pri),
      .greater      (c_greater[i]),
      .occ_r        (c_occ_r[i]),
      .value_r      (c_value_r[i]),
      .pri_r        (c_pri_r[i]),
      .occ_nxt      (c_occ_nxt[i]),
      .value_nxt    (c_value_nxt[i]),
      .pri_nxt      (c_pri_nxt[i])
    );
  end

  // result fields from the head cell after the operation
  always_comb begin
    head_pri_ext = '0;
    if (c_occ_nxt[0]) begin
      head_pri_ext[PRIORITY_BITS-1:0] = c_pri_nxt[0];
    end
    cnt_ext         = '0;
    cnt_ext[CW-1:0] = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r[31:0]  <= c_occ_nxt[0] ? c_value_nxt[0] : 32'd0;
      out_data_r[47:32] <= head_pri_ext[15:0];
      out_data_r[52:48] <= cnt_ext[4:0];
      out_data_r[55:53] <= 3'd0;
      out_user_r        <= {c_occ_nxt[0], status};
    end
  end

  // the count never runs past the cell row
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // head cell occupancy agrees with the count
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    c_occ_r[0] == (count_r != '0))
    else $error("head cell occupancy disagrees with count");

  // tail cell occupancy agrees with a full count
  a_tail_occ: assert property (@(posedge clk) disable iff (!rst_n)
    c_occ_r[DEPTH-1] == (count_r == CW'(DEPTH)))
    else $error("tail cell occupancy disagrees with full count");

  // a dequeue on a nonempty queue shifts the row and drops one entry
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == MODE_DEQ) && !empty) |=>
      ((count_r + 1'b1) == $past(count_r)))
    else $error("dequeue did not drop one entry");

endmodule

`default_nettype wire

### dv/spq_checker.sv
module spq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [47:0] in_tdata,   // [31:0] item_value, [47:32] item_priority
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [55:0] out_tdata,  // [31:0] head_value, [47:32] head_priority,
                                  // [52:48] entry_count, [55:53] zero
  input  wire  [2:0]  out_tuser,  // [1:0] status, [2] head_valid
  output int unsigned mismatches,
  output int unsigned waiting,
  output int unsigned beats_checked,
  output int unsigned full_drops,
  output int unsigned empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  typedef struct packed {
    logic [1:0]             status;
    logic                   head_valid;
    logic [VALUE_W-1:0]     head_value;
    logic [PRIO_FIELD-1:0]  head_priority;
    logic [COUNT_FIELD-1:0] entry_count;
  } head_report_t;

  // shadow copy of the queue, position 0 is the head
  logic [VALUE_W-1:0]    slot_val [DEPTH];
  logic [PRIO_FIELD-1:0] slot_pri [DEPTH];
  int unsigned           fill;
  head_report_t          head_expect_q [$];

  // apply one operation to the shadow queue, return the expected result
  function automatic head_report_t apply_op(input logic [1:0] mode,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [PRIO_FIELD-1:0] prio);
    head_report_t r;
    int unsigned  pos;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_ENQ) begin
      if (fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // goes behind every entry of equal or smaller priority
        pos = 0;
        while (pos < fill && slot_pri[pos] <= prio) pos++;
        for (int unsigned k = fill; k > pos; k--) begin
          slot_val[k] = slot_val[k-1];
          slot_pri[k] = slot_pri[k-1];
        end
        slot_val[pos] = value;
        slot_pri[pos] = prio;
        fill++;
      end
    end else if (mode == MODE_DEQ) begin
      if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int unsigned k = 0; k + 1 < fill; k++) begin
          slot_val[k] = slot_val[k+1];
          slot_pri[k] = slot_pri[k+1];
        end
        fill--;
      end
    end else if (fill == 0) begin
      // peek, and the spare code acting as one
      r.status = ST_EMPTY;
    end
    if (fill > 0) begin
      r.head_valid    = 1'b1;
      r.head_value    = slot_val[0];
      r.head_priority = slot_pri[0];
    end
    r.entry_count = COUNT_FIELD'(fill);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // beats are sampled at the edge that accepts them
  always @(posedge clk) begin : mon
    head_report_t want;
    if (!rst_n) begin
      fill = 0;
      head_expect_q.delete();
      waiting       = 0;
      mismatches    = 0;
      beats_checked = 0;
      full_drops    = 0;
      empty_hits    = 0;
    end else begin
      // push first so a same-edge result still pops the oldest expectation
      if (in_tvalid && in_tready)
        head_expect_q.push_back(apply_op(in_tuser, in_tdata[31:0], in_tdata[47:32]));
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (head_expect_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", 64'(out_tdata), '0);
        end else begin
          want = head_expect_q.pop_front();
          if (out_tuser[1:0] != want.status)
            report_mismatch("status", 64'(out_tuser[1:0]), 64'(want.status));
          if (out_tuser[2] != want.head_valid)
            report_mismatch("head_valid", 64'(out_tuser[2]), 64'(want.head_valid));
          if (out_tdata[31:0] != want.head_value)
            report_mismatch("head_value", 64'(out_tdata[31:0]), 64'(want.head_value));
          if (out_tdata[47:32] != want.head_priority)
            report_mismatch("head_priority", 64'(out_tdata[47:32]),
                            64'(want.head_priority));
          if (out_tdata[52:48] != want.entry_count)
            report_mismatch("entry_count", 64'(out_tdata[52:48]),
                            64'(want.entry_count));
          if (out_tdata[55:53] != 3'b000)
            report_mismatch("tdata pad bits", 64'(out_tdata[55:53]), '0);
          if (want.status == ST_FULL) full_drops++;
          if (want.status == ST_EMPTY) empty_hits++;
        end
      end
      waiting = head_expect_q.size();
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam logic [1:0]  MODE_SPARE = 2'd3;  // unused code, acts as a peek
  localparam int unsigned QDEPTH     = 16;
  localparam int unsigned SEGMENTS   = 15;
  localparam int unsigned SEG_ITEMS  = 40;
  localparam int unsigned QUIET_SEG  = 13;    // segments from here on run without idling
  localparam int unsigned TAIL       = 20;
  localparam int unsigned LIMIT      = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // [31:0] item_value, [47:32] item_priority
  logic [1:0]  in_tuser   = '0;  // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;        // [31:0] head_value, [47:32] head_priority,
                                 // [52:48] entry_count, [55:53] zero
  logic [2:0]  out_tuser;        // [1:0] status, [2] head_valid

  int unsigned mismatches, waiting, beats_checked, full_drops, empty_hits;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned gap_pct    = 0;
  bit          quiet      = 1'b0;
  bit          rx_stall_ok = 1'b0;

  sorted_priority_queue #(
    .DEPTH         (QDEPTH),
    .PRIORITY_BITS (16)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  spq_checker #(
    .DEPTH (QDEPTH)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .waiting       (waiting),
    .beats_checked (beats_checked),
    .full_drops    (full_drops),
    .empty_hits    (empty_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, waiting);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: back-pressure in random bursts
  initial begin : rx_side
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_stall_ok && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one operation beat, then maybe an idle burst
  task automatic send_beat(input logic [1:0] mode, input logic [31:0] value,
                           input logic [15:0] prio);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {prio, value};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stim
    logic [15:0] fill_pri [16];
    logic [31:0] corner_val [4];
    logic [1:0]  mode;
    logic [15:0] prio;
    int unsigned enq_pct;
    int unsigned roll;

    fill_pri   = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0007, 16'hFFFF, 16'h0003,
                   16'h0007, 16'h0000, 16'h0001, 16'h8000, 16'h0007, 16'h0002,
                   16'hFFFE, 16'h0000, 16'h0005, 16'hFFFF};
    corner_val = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_stall_ok = 1'b1;
    gap_pct     = 20;

    // directed: empty queue ops, fill with extremes and ties, overflow, peek, one dequeue
    send_beat(MODE_PEEK, 32'h1234_5678, 16'h00FF);
    send_beat(MODE_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(MODE_SPARE, 32'h0, 16'h0);
    for (int i = 0; i < 16; i++)
      send_beat(MODE_ENQ, (i < 4) ? corner_val[i] : $urandom, fill_pri[i]);
    send_beat(MODE_ENQ, 32'hDEAD_BEEF, 16'h0000);
    send_beat(MODE_PEEK, $urandom, 16'($urandom));
    send_beat(MODE_SPARE, $urandom, 16'($urandom));
    send_beat(MODE_DEQ, $urandom, 16'($urandom));

    // random segments, each biased toward filling, draining or balanced
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 75;
        1: enq_pct = 25;
        default: enq_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      quiet       = (seg >= QUIET_SEG);
      rx_stall_ok = !quiet;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          mode = MODE_SPARE;
        else if (roll < 12)
          mode = MODE_PEEK;
        else if ($urandom_range(0, 99) < enq_pct)
          mode = MODE_ENQ;
        else
          mode = MODE_DEQ;
        // mostly a few close priorities so ties are common
        case ($urandom_range(0, 3))
          0, 1: prio = 16'($urandom_range(0, 3));
          2: prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: prio = 16'($urandom);
        endcase
        send_beat(mode, $urandom, prio);
      end
    end

    in_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (TAIL) @(posedge clk);

    $display("%0d operation beats sent, %0d result beats checked", items_sent, beats_checked);
    $display("%0d enqueues dropped on a full queue, %0d ops on an empty queue",
             full_drops, empty_hits);
    if (mismatches == 0 && waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
dv/spq_checker.sv
dv/tb_top.sv
